@@ sv/ehp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehp_pkg: shared types and constants of the Ethernet/IPv4 header parser
// Result item layout, protocol codes and the frame size limit.
// ----------------------------------------------------------------------------
`default_nettype none

package ehp_pkg;

  // Largest number of frame bytes that are looked at.
  localparam int MaxFrameBytes = 65535;

  // Depth of the result queue; a step writes up to two items.
  localparam int QueueDepth = 4;

  // Stream widths.
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 208;

  // Header constants.
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  IpProtoIcmp   = 8'd1;
  localparam logic [7:0]  IpProtoTcp    = 8'd6;
  localparam logic [7:0]  IpProtoUdp    = 8'd17;
  localparam logic [3:0]  MinWords      = 4'd5;
  localparam logic [7:0]  CharLow       = 8'd32;
  localparam logic [7:0]  CharHigh      = 8'd126;
  localparam logic [7:0]  CharDot       = 8'd46;

  // Protocol code of a header record.
  typedef enum logic [1:0] {
    PROTO_ICMP = 2'd0,
    PROTO_TCP  = 2'd1,
    PROTO_UDP  = 2'd2
  } proto_code_t;

  // Kind of a result item.
  typedef enum logic {
    KIND_CHAR   = 1'b0,
    KIND_RECORD = 1'b1
  } item_kind_t;

  // One result item.
  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  payload_char;
    logic [47:0] mac_src;
    logic [47:0] mac_dst;
    logic [31:0] ip_src;
    logic [31:0] dest_ip;
    proto_code_t proto_code;
    logic [15:0] port_src;
    logic [15:0] port_dst;
    logic        record_last;
  } result_t;

  // Results of one step, handed to the queue in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

@@ sv/ehp_parser.sv @@
// ----------------------------------------------------------------------------
// ehp_parser: header field capture and result generation
// Tracks the byte position of the frame, captures header fields and produces
// the payload character and the closing header record of each step.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_parser #(
  parameter int MAX_FRAME_BYTES = ehp_pkg::MaxFrameBytes
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_take,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end,
  output ehp_pkg::push_t     push
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW = (PW > 8) ? PW + 1 : 9;

  // Frame state.
  logic [PW-1:0] byte_position;
  logic [47:0]   src_mac_reg;
  logic [47:0]   dst_mac_reg;
  logic [15:0]   ether_type_reg;
  logic [3:0]    header_words;
  logic [7:0]    ip_proto_reg;
  logic [31:0]   src_ip_reg;
  logic [31:0]   dst_ip_reg;
  logic [15:0]   src_port_reg;
  logic [15:0]   dst_port_reg;
  logic [3:0]    tcp_offset_words;

  // Values after this byte's capture.
  logic [47:0] src_mac_next;
  logic [47:0] dst_mac_next;
  logic [15:0] ether_type_next;
  logic [3:0]  header_words_next;
  logic [7:0]  ip_proto_next;
  logic [31:0] src_ip_next;
  logic [31:0] dst_ip_next;
  logic [15:0] src_port_next;
  logic [15:0] dst_port_next;
  logic [3:0]  tcp_offset_next;

  logic          capture_en;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] count_w;
  logic [7:0]    transport_start;
  logic [CW-1:0] t_w;
  logic [7:0]    payload_start;
  logic [CW-1:0] ps_w;
  logic          frame_ok;
  logic          emit_char;
  logic          emit_record;
  logic [7:0]    mapped_char;
  ehp_pkg::proto_code_t code;
  ehp_pkg::result_t     char_item;
  ehp_pkg::result_t     record_item;

  assign capture_en = in_take && (byte_position < PW'(MAX_FRAME_BYTES));
  assign pos_w      = CW'(byte_position);
  assign count_w    = capture_en ? pos_w + CW'(1) : pos_w;

  // The transport header starts after the Ethernet and IPv4 headers.
  assign transport_start = 8'd14 + {2'b00, header_words, 2'b00};
  assign t_w             = CW'(transport_start);

  // Field capture at the current byte position.
  always_comb begin
    src_mac_next      = src_mac_reg;
    dst_mac_next      = dst_mac_reg;
    ether_type_next   = ether_type_reg;
    header_words_next = header_words;
    ip_proto_next     = ip_proto_reg;
    src_ip_next       = src_ip_reg;
    dst_ip_next       = dst_ip_reg;
    src_port_next     = src_port_reg;
    dst_port_next     = dst_port_reg;
    tcp_offset_next   = tcp_offset_words;
    if (capture_en) begin
      if (pos_w < CW'(6)) begin
        dst_mac_next = {dst_mac_reg[39:0], in_byte};
      end else if (pos_w < CW'(12)) begin
        src_mac_next = {src_mac_reg[39:0], in_byte};
      end else if (pos_w < CW'(14)) begin
        ether_type_next = {ether_type_reg[7:0], in_byte};
      end else if (pos_w == CW'(14)) begin
        header_words_next = in_byte[3:0];
      end else if (pos_w == CW'(23)) begin
        ip_proto_next = in_byte;
      end else if (pos_w >= CW'(26) && pos_w < CW'(30)) begin
        src_ip_next = {src_ip_reg[23:0], in_byte};
      end else if (pos_w >= CW'(30) && pos_w < CW'(34)) begin
        dst_ip_next = {dst_ip_reg[23:0], in_byte};
      end
      if (header_words >= ehp_pkg::MinWords && pos_w >= t_w) begin
        if (pos_w < t_w + CW'(2)) begin
          src_port_next = {src_port_reg[7:0], in_byte};
        end else if (pos_w < t_w + CW'(4)) begin
          dst_port_next = {dst_port_reg[7:0], in_byte};
        end else if (pos_w == t_w + CW'(12)) begin
          tcp_offset_next = in_byte[7:4];
        end
      end
    end
  end

  // Payload start and frame check on the updated fields.
  always_comb begin
    if (ip_proto_next == ehp_pkg::IpProtoTcp) begin
      payload_start = transport_start + {2'b00, tcp_offset_next, 2'b00};
    end else if (ip_proto_next == ehp_pkg::IpProtoUdp) begin
      payload_start = transport_start + 8'd8;
    end else begin
      payload_start = transport_start;
    end
    frame_ok = 1'b0;
    if (ether_type_next == ehp_pkg::EtherTypeIpv4 && header_words_next >= ehp_pkg::MinWords)
    begin
      if (ip_proto_next == ehp_pkg::IpProtoIcmp || ip_proto_next == ehp_pkg::IpProtoUdp) begin
        frame_ok = 1'b1;
      end else if (ip_proto_next == ehp_pkg::IpProtoTcp) begin
        frame_ok = tcp_offset_next >= ehp_pkg::MinWords;
      end
    end
  end

  assign ps_w        = CW'(payload_start);
  assign emit_char   = capture_en && frame_ok && (pos_w >= ps_w);
  assign emit_record = in_take && in_end && frame_ok && (count_w >= ps_w);

  assign mapped_char = (in_byte >= ehp_pkg::CharLow && in_byte <= ehp_pkg::CharHigh) ?
                       in_byte : ehp_pkg::CharDot;

  always_comb begin
    if (ip_proto_next == ehp_pkg::IpProtoTcp) begin
      code = ehp_pkg::PROTO_TCP;
    end else if (ip_proto_next == ehp_pkg::IpProtoUdp) begin
      code = ehp_pkg::PROTO_UDP;
    end else begin
      code = ehp_pkg::PROTO_ICMP;
    end
  end

  // Build the result items.
  always_comb begin
    char_item              = '0;
    char_item.item_kind    = ehp_pkg::KIND_CHAR;
    char_item.payload_char = mapped_char;

    record_item              = '0;
    record_item.item_kind    = ehp_pkg::KIND_RECORD;
    record_item.mac_src      = src_mac_next;
    record_item.mac_dst      = dst_mac_next;
    record_item.ip_src       = src_ip_next;
    record_item.dest_ip      = dst_ip_next;
    record_item.proto_code   = code;
    record_item.port_src     = (code == ehp_pkg::PROTO_ICMP) ? 16'd0 : src_port_next;
    record_item.port_dst     = (code == ehp_pkg::PROTO_ICMP) ? 16'd0 : dst_port_next;
    record_item.record_last  = 1'b1;
  end

  // Order the items: the character comes before the record.
  always_comb begin
    push.count  = {1'b0, emit_char} + {1'b0, emit_record};
    push.first  = emit_char ? char_item : record_item;
    push.second = record_item;
  end

  // State update; every frame end clears the frame state.
  always_ff @(posedge clk) begin
    if (rst || (in_take && in_end)) begin
      byte_position    <= '0;
      src_mac_reg      <= '0;
      dst_mac_reg      <= '0;
      ether_type_reg   <= '0;
      header_words     <= '0;
      ip_proto_reg     <= '0;
      src_ip_reg       <= '0;
      dst_ip_reg       <= '0;
      src_port_reg     <= '0;
      dst_port_reg     <= '0;
      tcp_offset_words <= '0;
    end else if (capture_en) begin
      byte_position    <= byte_position + PW'(1);
      src_mac_reg      <= src_mac_next;
      dst_mac_reg      <= dst_mac_next;
      ether_type_reg   <= ether_type_next;
      header_words     <= header_words_next;
      ip_proto_reg     <= ip_proto_next;
      src_ip_reg       <= src_ip_next;
      dst_ip_reg       <= dst_ip_next;
      src_port_reg     <= src_port_next;
      dst_port_reg     <= dst_port_next;
      tcp_offset_words <= tcp_offset_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/ehp_out_queue.sv @@
// ----------------------------------------------------------------------------
// ehp_out_queue: result queue
// Takes up to two result items per cycle and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ehp_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ehp_pkg::result_t    out_item
);

  localparam int Depth = ehp_pkg::QueueDepth;
  localparam int AW    = $clog2(Depth);

  ehp_pkg::result_t entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          pop;
  logic [AW:0]   fill_next;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign out_item  = entries[rd_ptr];
  // Room for a full step of two items.
  assign room      = fill <= (AW + 1)'(Depth - 2);
  assign fill_next = fill + (AW + 1)'(push.count) - (AW + 1)'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      fill   <= fill_next;
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + AW'(1)] <= push.second;
    end
  end

endmodule

`default_nettype wire

@@ sv/ethernet_ip_header_parser.sv @@
// ----------------------------------------------------------------------------
// ethernet_ip_header_parser: Ethernet/IPv4 ICMP, TCP and UDP header parser
// Takes a frame one byte per item, emits its payload as printable characters
// and, at frame end, one header record with MACs, addresses and ports.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Item
//   s_axis    in         one frame byte, tlast on the last byte of the frame
//   m_axis    out        payload character or header record (tuser = kind)
//
// One frame byte is taken every cycle while the queue has room; field capture,
// the payload check and the result building are combinational, ahead of a
// four-entry result queue. A frame's last byte may give two items, which drain in order.
// Input is stalled only while the queue holds more than two items.
// rst is synchronous and clears the frame state and the queue.
`default_nettype none

module ethernet_ip_header_parser #(
  parameter int MAX_FRAME_BYTES = ehp_pkg::MaxFrameBytes
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ehp_pkg::InTdataW-1:0]  s_axis_tdata,  // [7:0] frame_byte
  input  wire logic                          s_axis_tlast,  // frame_end
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] payload_char, [55:8] mac_src, [103:56] mac_dst,
  // [135:104] ip_src, [167:136] dest_ip, [169:168] proto_code,
  // [185:170] port_src, [201:186] port_dst, [207:202] zero
  output logic [ehp_pkg::OutTdataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tuser,  // [0] item_kind
  output logic                               m_axis_tlast   // record_last
);

  logic             take;
  logic             room;
  ehp_pkg::push_t   push;
  ehp_pkg::result_t out_item;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  ehp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_take (take),
    .in_byte (s_axis_tdata[7:0]),
    .in_end  (s_axis_tlast),
    .push    (push)
  );

  ehp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  // Pack the result item onto the output stream.
  assign m_axis_tdata = {6'd0,
                         out_item.port_dst,
                         out_item.port_src,
                         out_item.proto_code,
                         out_item.dest_ip,
                         out_item.ip_src,
                         out_item.mac_dst,
                         out_item.mac_src,
                         out_item.payload_char};
  assign m_axis_tuser = out_item.item_kind;
  assign m_axis_tlast = out_item.record_last;

endmodule

`default_nettype wire

@@ tb/sv/ethernet_ip_header_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ip_header_parser_tb: self-checking bench for the header parser
// Frames are streamed in byte by byte, with bursts and gaps on the input and
// a changing stall pattern on the output. A scoreboard parses every accepted
// byte the same way the block should and checks each payload character and
// header record in order, field by field.
// ----------------------------------------------------------------------------
module ethernet_ip_header_parser_tb;
  import ehp_pkg::*;

  localparam int          CycleLimit    = 200_000;
  localparam int          DrainCycles   = 20;
  localparam int          HoldCycles    = 400;
  localparam int          RandBytes     = 550;
  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
  localparam logic [7:0]  IpProtoIgmp   = 8'd2;

  // How the header bytes that no field is forced into get filled.
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  // Output stall patterns.
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: parses accepted bytes and holds the result items they cause.
  // --------------------------------------------------------------------------
  class frame_parse_checker;
    result_t     pending_items[$];
    int          mismatches;
    logic [15:0] pos;
    logic [47:0] src_mac, dst_mac;
    logic [15:0] ether_type;
    logic [3:0]  ip_words;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip, dst_ip;
    logic [15:0] src_port, dst_port;
    logic [3:0]  tcp_words;
    logic [15:0] payload_at;

    function new();
      mismatches  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = '0;
      src_mac    = '0;
      dst_mac    = '0;
      ether_type = '0;
      ip_words   = '0;
      ip_proto   = '0;
      src_ip     = '0;
      dst_ip     = '0;
      src_port   = '0;
      dst_port   = '0;
      tcp_words  = '0;
      payload_at = '0;
    endfunction

    function bit frame_ok();
      if (ether_type != EtherTypeIpv4 || ip_words < MinWords) return 1'b0;
      if (ip_proto == IpProtoIcmp || ip_proto == IpProtoUdp) return 1'b1;
      return ip_proto == IpProtoTcp && tcp_words >= MinWords;
    endfunction

    function int pending();
      return pending_items.size();
    endfunction

    // Parse one accepted frame byte and queue what it should produce.
    function void absorb_byte(logic [7:0] b, logic last);
      logic [15:0] p;
      logic [15:0] t;
      result_t     r;
      p = pos;
      if (p < MaxFrameBytes) begin
        // The transport offset uses the header length as it stood before this byte.
        t = 16'd14 + {10'd0, ip_words, 2'b00};
        if (p < 6) dst_mac = {dst_mac[39:0], b};
        else if (p < 12) src_mac = {src_mac[39:0], b};
        else if (p < 14) ether_type = {ether_type[7:0], b};
        else if (p == 14) ip_words = b[3:0];
        else if (p == 23) ip_proto = b;
        else if (p >= 26 && p < 30) src_ip = {src_ip[23:0], b};
        else if (p >= 30 && p < 34) dst_ip = {dst_ip[23:0], b};

        if (ip_words >= MinWords && p >= t) begin
          if (p < t + 16'd2) src_port = {src_port[7:0], b};
          else if (p < t + 16'd4) dst_port = {dst_port[7:0], b};
          else if (p == t + 16'd12) tcp_words = b[7:4];
        end

        if (ip_proto == IpProtoTcp) payload_at = t + {10'd0, tcp_words, 2'b00};
        else if (ip_proto == IpProtoUdp) payload_at = t + 16'd8;
        else payload_at = t;

        pos = p + 16'd1;
        if (frame_ok() && p >= payload_at) begin
          r              = '0;
          r.item_kind    = KIND_CHAR;
          r.payload_char = (b >= CharLow && b <= CharHigh) ? b : CharDot;
          r.proto_code   = PROTO_ICMP;
          pending_items.push_back(r);
        end
      end

      // The frame end closes the frame and may add the header record.
      if (last) begin
        if (frame_ok() && pos >= payload_at) begin
          r             = '0;
          r.item_kind   = KIND_RECORD;
          r.mac_src     = src_mac;
          r.mac_dst     = dst_mac;
          r.ip_src      = src_ip;
          r.dest_ip     = dst_ip;
          r.proto_code  = (ip_proto == IpProtoTcp) ? PROTO_TCP :
                          ((ip_proto == IpProtoUdp) ? PROTO_UDP : PROTO_ICMP);
          r.port_src    = (ip_proto == IpProtoIcmp) ? 16'd0 : src_port;
          r.port_dst    = (ip_proto == IpProtoIcmp) ? 16'd0 : dst_port;
          r.record_last = 1'b1;
          pending_items.push_back(r);
        end
        clear_frame();
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result item against the oldest expectation.
    function void compare_item(logic [OutTdataW-1:0] data, logic kind, logic last);
      result_t e;
      if (pending_items.size() == 0) begin
        $error("result item with nothing expected: kind %0b, tdata 0x%0h", kind, data);
        mismatches++;
        return;
      end
      e = pending_items.pop_front();
      check_field("item_kind", e.item_kind, kind);
      check_field("payload_char", e.payload_char, data[7:0]);
      check_field("mac_src", e.mac_src, data[55:8]);
      check_field("mac_dst", e.mac_dst, data[103:56]);
      check_field("ip_src", e.ip_src, data[135:104]);
      check_field("dest_ip", e.dest_ip, data[167:136]);
      check_field("proto_code", e.proto_code, data[169:168]);
      check_field("port_src", e.port_src, data[185:170]);
      check_field("port_dst", e.port_dst, data[201:186]);
      check_field("tdata padding", 64'd0, data[207:202]);
      check_field("record_last", e.record_last, last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  always #2 clk = ~clk;

  ethernet_ip_header_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  frame_parse_checker frame_check;
  logic [7:0]         frame_q[$];
  int                 burst_left = 0;
  logic               hold_req = 1'b0;
  int                 cycles = 0;

  // Every handshake is seen at the rising edge; inputs are noted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) frame_check.absorb_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        frame_check.compare_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: one long hold-off on request, otherwise a changing pattern.
  // --------------------------------------------------------------------------
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       rx_phase = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_phase % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= (rx_phase % 4 == 0);
        default:   m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Lay out one frame in frame_q; fields not forced here follow the fill.
  function automatic void build_frame(input fill_t fill, input logic [15:0] etype,
                                      input logic [3:0] ihl, input logic [7:0] proto,
                                      input logic [3:0] toff, input int pay_len);
    int ip_len;
    int l4_len;
    int tp;
    int total;
    ip_len = (ihl >= MinWords) ? 4 * ihl : 20;
    if (proto == IpProtoTcp) l4_len = (toff >= MinWords) ? 4 * toff : 20;
    else if (proto == IpProtoIcmp) l4_len = 0;
    else l4_len = 8;
    total = 14 + ip_len + l4_len + pay_len;
    frame_q.delete();
    for (int i = 0; i < total; i++) begin
      case (fill)
        FILL_ZERO: frame_q.push_back(8'h00);
        FILL_ONES: frame_q.push_back(8'hFF);
        default:   frame_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    frame_q[12] = etype[15:8];
    frame_q[13] = etype[7:0];
    frame_q[14] = {frame_q[14][7:4], ihl};
    frame_q[23] = proto;
    tp = 14 + ip_len;
    if (proto == IpProtoTcp) frame_q[tp + 12] = {toff, frame_q[tp + 12][3:0]};
  endfunction

  function automatic void cut_frame(input int keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endfunction

  // One byte, held until taken; returns at the next falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Send frame_q in bursts with random gaps between them.
  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame_q.size(); i++) begin
      if (burst_left == 0) begin
        case ($urandom_range(0, 9))
          0:       gap = 0;
          1, 2:    gap = $urandom_range(5, 15);
          default: gap = $urandom_range(1, 4);
        endcase
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 48);
      end
      send_byte(frame_q[i], i == frame_q.size() - 1);
      burst_left--;
    end
  endtask

  // Stop offering until every expected item has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (frame_check.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One random frame: mostly well formed, the rest broken or noise.
  task automatic random_frame();
    int          pick;
    fill_t       fill;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [3:0]  toff;
    logic [7:0]  proto;
    pick  = $urandom_range(0, 99);
    fill  = ($urandom_range(0, 19) == 0) ? fill_t'($urandom_range(1, 2)) : FILL_RANDOM;
    etype = EtherTypeIpv4;
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MinWords;
    toff  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MinWords;
    case ($urandom_range(0, 2))
      0:       proto = IpProtoIcmp;
      1:       proto = IpProtoTcp;
      default: proto = IpProtoUdp;
    endcase
    if (pick >= 70 && pick < 75) begin
      do etype = 16'($urandom); while (etype == EtherTypeIpv4);
    end else if (pick >= 75 && pick < 80) begin
      do proto = 8'($urandom);
      while (proto == IpProtoIcmp || proto == IpProtoTcp || proto == IpProtoUdp);
    end else if (pick >= 80 && pick < 84) begin
      ihl = 4'($urandom_range(0, 4));
    end else if (pick >= 84 && pick < 88) begin
      proto = IpProtoTcp;
      toff  = 4'($urandom_range(0, 4));
    end
    build_frame(fill, etype, ihl, proto, toff, $urandom_range(0, 20));
    if (pick >= 88 && pick < 95) cut_frame($urandom_range(1, frame_q.size() - 1));
    if (pick >= 95) begin
      frame_q.delete();
      repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_bytes;
    int frames;
    frame_check = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ICMP payload around the printable limits.
    build_frame(FILL_RANDOM, EtherTypeIpv4, MinWords, IpProtoIcmp, 4'd0, 8);
    frame_q[frame_q.size() - 8] = 8'd0;
    frame_q[frame_q.size() - 7] = 8'd31;
    frame_q[frame_q.size() - 6] = 8'd32;
    frame_q[frame_q.size() - 5] = 8'd46;
    frame_q[frame_q.size() - 4] = 8'd126;
    frame_q[frame_q.size() - 3] = 8'd127;
    frame_q[frame_q.size() - 2] = 8'd128;
    frame_q[frame_q.size() - 1] = 8'd255;
    send_frame();
    // Extreme field values, longest headers and empty payloads.
    build_frame(FILL_ONES, EtherTypeIpv4, 4'd15, IpProtoUdp, 4'd0, 0);
    send_frame();
    build_frame(FILL_ZERO, EtherTypeIpv4, MinWords, IpProtoUdp, 4'd0, 4);
    send_frame();
    build_frame(FILL_ONES, EtherTypeIpv4, MinWords, IpProtoTcp, 4'd15, 5);
    send_frame();
    build_frame(FILL_ZERO, EtherTypeIpv4, 4'd15, IpProtoTcp, MinWords, 3);
    send_frame();
    build_frame(FILL_RANDOM, EtherTypeIpv4, MinWords, IpProtoTcp, MinWords, 0);
    send_frame();
    // Frames that must stay silent.
    build_frame(FILL_RANDOM, EtherTypeIpv6, MinWords, IpProtoUdp, 4'd0, 6);
    send_frame();
    build_frame(FILL_RANDOM, EtherTypeIpv4, MinWords, IpProtoIgmp, 4'd0, 6);
    send_frame();
    build_frame(FILL_RANDOM, EtherTypeIpv4, 4'd4, IpProtoUdp, 4'd0, 6);
    send_frame();
    build_frame(FILL_RANDOM, EtherTypeIpv4, MinWords, IpProtoTcp, 4'd4, 6);
    send_frame();
    // Truncated before the payload start, and very short frames.
    build_frame(FILL_RANDOM, EtherTypeIpv4, MinWords, IpProtoUdp, 4'd0, 4);
    cut_frame(40);
    send_frame();
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    frame_q.push_back(8'h00);
    send_frame();
    wait_drain();

    // Random frames; the output holds off for a long stretch at the start.
    hold_req <= 1'b1;
    rand_bytes = 0;
    frames     = 0;
    while (rand_bytes < RandBytes) begin
      if (frames != 0 && frames % 10 == 0) wait_drain();
      random_frame();
      rand_bytes += frame_q.size();
      frames++;
    end

    // Let everything drain, then watch for stray items.
    s_axis_tvalid <= 1'b0;
    while (frame_check.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (frame_check.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ehp_pkg.sv
sv/ehp_parser.sv
sv/ehp_out_queue.sv
sv/ethernet_ip_header_parser.sv
tb/sv/ethernet_ip_header_parser_tb.sv
